FILE: sv/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants for the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int unsigned KeyW       = 64;
  localparam int unsigned HandleW    = 16;
  localparam int unsigned SlotOutW   = 4;
  localparam int unsigned MaxKeyBytes = 8;
  // (h + c) * c with h, c below 256 stays below 2^17
  localparam int unsigned ProdW      = 17;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] record_handle;
  } lph_req_t;

  typedef struct packed {
    logic                ok;
    logic [HandleW-1:0]  found_handle;
    logic [SlotOutW-1:0] slot_index;
  } lph_rsp_t;

  // one RAM word per slot; empty slots are tracked by valid flops
  typedef struct packed {
    logic               tomb;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } lph_entry_t;

  typedef struct packed {
    logic load;          // capture request, start hash
    logic hash_step;     // fold next key byte
    logic probe_start;   // pointer to home slot
    logic advance;       // next slot
    logic ram_rd;        // read slot at pointer
    logic write_insert;  // store key and handle at pointer
    logic write_tomb;    // mark slot at pointer deleted
    logic res_load;      // load result register
    logic res_hit;       // result is a hit
  } lph_cmd_t;

  typedef struct packed {
    logic       hash_done;
    logic       mod_busy;
    logic       slot_valid;
    logic       probe_last;
    logic       key_match;
    logic [1:0] kind;
  } lph_status_t;

endpackage

FILE: sv/linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table with linear probing: insert, lookup, delete.
// ----------------------------------------------------------------------------
// Flow: the request is captured, the key is folded one byte per hash step
//   (reciprocal remainder unit when SLOTS is not a power of two), then slots
//   are probed from the home slot; lookup/delete read each occupied slot
//   from the single-port slot RAM (registered read) and compare its key.
// Throughput: one request at a time; the next is taken once the result sits
//   in the output register. Reset: all slots empty at once via valid flops.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core
  import lph_pkg::*;
#(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  // request channel
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lph_req_t in_req_i,
  // result channel
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lph_rsp_t out_rsp_o
);

  // Controller drives commands, datapath reports status; nothing else crosses.
  lph_cmd_t    cmd;
  lph_status_t st;

  lph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Datapath holds the captured request, the hash fold, the probe pointer,
  // slot valid flops (empty vs written) and the slot RAM (key, handle, tomb).
  lph_dp #(
    .SLOTS    (SLOTS),
    .KEY_BYTES(KEY_BYTES)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (in_req_i),
    .cmd_i (cmd),
    .st_o  (st),
    .rsp_o (out_rsp_o)
  );

endmodule

FILE: sv/lph_ram.sv
// ----------------------------------------------------------------------------
// lph_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/lph_ctrl.sv
// ----------------------------------------------------------------------------
// lph_ctrl
// Sequencer: hash, probe, compare and result handover.
// ----------------------------------------------------------------------------
module lph_ctrl
  import lph_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  lph_status_t st_i,
  output lph_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_INS,
    ST_LK_ADDR,
    ST_LK_CMP,
    ST_DONE_HIT,
    ST_DONE_MISS
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q) inside
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_HASH;
        end
      end
      ST_HASH: begin
        if (st_i.hash_done) begin
          case (st_i.kind) inside
            KIND_INSERT: begin
              cmd_o.probe_start = 1'b1;
              state_d           = ST_INS;
            end
            KIND_LOOKUP, KIND_DELETE: begin
              cmd_o.probe_start = 1'b1;
              state_d           = ST_LK_ADDR;
            end
            default: state_d = ST_DONE_MISS;
          endcase
        end else if (!st_i.mod_busy) begin
          cmd_o.hash_step = 1'b1;
        end
      end
      ST_INS: begin
        if (!st_i.slot_valid) begin
          cmd_o.write_insert = 1'b1;
          state_d            = ST_DONE_HIT;
        end else if (st_i.probe_last) begin
          state_d = ST_DONE_MISS;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_LK_ADDR: begin
        if (st_i.slot_valid) begin
          cmd_o.ram_rd = 1'b1;
          state_d      = ST_LK_CMP;
        end else if (st_i.probe_last) begin
          state_d = ST_DONE_MISS;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_LK_CMP: begin
        if (st_i.key_match) begin
          cmd_o.write_tomb = (st_i.kind == KIND_DELETE);
          state_d          = ST_DONE_HIT;
        end else if (st_i.probe_last) begin
          state_d = ST_DONE_MISS;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_LK_ADDR;
        end
      end
      ST_DONE_HIT, ST_DONE_MISS: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_hit  = (state_q == ST_DONE_HIT);
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/lph_dp.sv
// ----------------------------------------------------------------------------
// lph_dp
// Datapath: key cut, byte-serial hash fold, probe pointer, slot store.
// ----------------------------------------------------------------------------
module lph_dp
  import lph_pkg::*;
#(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lph_req_t    req_i,
  input  lph_cmd_t    cmd_i,
  output lph_status_t st_o,
  output lph_rsp_t    rsp_o
);

  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LenW  = $clog2(MaxKeyBytes + 1);
  localparam bit          Pow2  = ((1 << IdxW) == SLOTS);
  localparam int unsigned EntW  = $bits(lph_entry_t);

  logic [1:0]         kind_q;
  logic [KeyW-1:0]    key_q;
  logic [HandleW-1:0] handle_q;
  logic [LenW-1:0]    len_q, byte_idx_q;
  logic [IdxW-1:0]    h_q;
  logic [IdxW-1:0]    ptr_q, cnt_q;
  logic [SLOTS-1:0]   valid_q;
  lph_rsp_t           rsp_q;

  // key cut at first zero byte or KEY_BYTES
  logic [KeyW-1:0] cut_key;
  logic [LenW-1:0] cut_len;
  always_comb begin
    logic alive;
    alive   = 1'b1;
    cut_key = '0;
    cut_len = '0;
    for (int b = 0; b < MaxKeyBytes; b++) begin
      alive = alive && (b < KEY_BYTES) && (req_i.key[b*8 +: 8] != 8'd0);
      if (alive) begin
        cut_key[b*8 +: 8] = req_i.key[b*8 +: 8];
        cut_len           = cut_len + 1'b1;
      end
    end
  end

  // hash fold: (h + c) * c
  logic [7:0]       cur_byte;
  logic [8:0]       hc_sum;
  logic [ProdW-1:0] prod;
  logic             hash_wr;
  logic [IdxW-1:0]  hash_wr_val;
  logic             mod_busy;

  assign cur_byte = key_q[{byte_idx_q[2:0], 3'b000} +: 8];
  assign hc_sum   = 9'(h_q) + 9'(cur_byte);
  assign prod     = ProdW'(hc_sum) * ProdW'(cur_byte);

  if (Pow2) begin : g_mod_mask
    assign hash_wr     = cmd_i.hash_step;
    assign hash_wr_val = prod[IdxW-1:0];
    assign mod_busy    = 1'b0;
  end else begin : g_mod_recip
    // remainder by reciprocal multiply: exact quotient registered in the first phase,
    // multiply back and subtract in the next
    localparam int unsigned RecSh = ProdW + IdxW;
    localparam int unsigned RecW  = ProdW + 1;
    localparam int unsigned MulW  = ProdW + RecW;
    localparam logic [RecW-1:0] Recip =
      RecW'(((64'd1 << RecSh) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

    logic [ProdW-1:0] prod_q, quo_q, quo_d, rem_d;
    logic [MulW-1:0]  mul_full;
    logic             busy_q, phase_q;

    assign mul_full = MulW'(prod_q) * MulW'(Recip);
    assign quo_d    = ProdW'(mul_full >> RecSh);
    assign rem_d    = prod_q - quo_q * ProdW'(SLOTS);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q  <= 1'b0;
        phase_q <= 1'b0;
      end else if (cmd_i.hash_step) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
      end else if (busy_q) begin
        busy_q  <= !phase_q;
        phase_q <= !phase_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.hash_step) begin
        prod_q <= prod;
      end
      if (busy_q && !phase_q) begin
        quo_q <= quo_d;
      end
    end

    assign hash_wr     = busy_q && phase_q;
    assign hash_wr_val = rem_d[IdxW-1:0];
    assign mod_busy    = busy_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= req_i.kind;
      key_q      <= cut_key;
      handle_q   <= req_i.record_handle;
      len_q      <= cut_len;
      byte_idx_q <= '0;
      h_q        <= '0;
    end else if (hash_wr) begin
      h_q        <= hash_wr_val;
      byte_idx_q <= byte_idx_q + 1'b1;
    end
    if (cmd_i.probe_start) begin
      ptr_q <= h_q;
      cnt_q <= IdxW'(SLOTS - 1);
    end else if (cmd_i.advance) begin
      ptr_q <= (ptr_q == IdxW'(SLOTS - 1)) ? '0 : ptr_q + 1'b1;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // slot store
  lph_entry_t ram_wdata, ram_rdata;
  logic       ram_we;

  assign ram_we = cmd_i.write_insert || cmd_i.write_tomb;

  always_comb begin
    ram_wdata.tomb   = cmd_i.write_tomb;
    ram_wdata.key    = key_q;
    ram_wdata.handle = handle_q;
  end

  lph_ram #(
    .Width(EntW),
    .Depth(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (cmd_i.ram_rd),
    .addr_i (ptr_q),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.write_insert) begin
      valid_q[ptr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      if (cmd_i.res_hit) begin
        rsp_q.ok           <= 1'b1;
        rsp_q.found_handle <= (kind_q == KIND_INSERT) ? '0 : ram_rdata.handle;
        rsp_q.slot_index   <= SlotOutW'(ptr_q);
      end else begin
        rsp_q <= '0;
      end
    end
  end

  assign rsp_o = rsp_q;

  always_comb begin
    st_o.hash_done  = (byte_idx_q == len_q) && !mod_busy;
    st_o.mod_busy   = mod_busy;
    st_o.slot_valid = valid_q[ptr_q];
    st_o.probe_last = (cnt_q == '0);
    st_o.key_match  = !ram_rdata.tomb && (ram_rdata.key == key_q);
    st_o.kind       = kind_q;
  end

  // insert only ever lands on a never-used slot
  a_ins_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_insert |-> !valid_q[ptr_q])
    else $error("insert onto an occupied slot");

  // delete only marks a live matching entry
  a_tomb_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_tomb |-> valid_q[ptr_q] && st_o.key_match)
    else $error("tombstone written without a match");

  // no new byte fold while the remainder unit is busy
  a_fold_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_busy |-> !cmd_i.hash_step)
    else $error("hash step during remainder");

  // probe pointer wraps inside the table
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.advance || cmd_i.probe_start) |-> ptr_q <= IdxW'(SLOTS - 1))
    else $error("probe pointer out of range");

endmodule

FILE: bench/tb_linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table_core
// Self-checking bench for the linear probing hash table. Requests go in over
// valid/ready. A slot table model predicts each result, and every result is
// compared field by field in order. A directed opening covers the empty key,
// the widest key, padding after the first zero byte, duplicates, tombstones,
// misses and the undefined kind. Random traffic in three idling phases then
// reuses inserted keys, and a closing burst of inserts fills the table.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table_core;
  import lph_pkg::*;

  // Must match the DUT parameters below
  localparam int unsigned Slots       = 16;
  localparam int unsigned KeyBytes    = 8;
  // Undefined operation code: the block must answer with an all-zero result
  localparam logic [1:0]  KindNone    = 2'd3;
  // Worst request takes 8 hash steps and probes all 16 slots.
  // Even with heavy stalls on both sides, about 750 requests stay well below this.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned RandomItems = 700;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_state_e;

  // --------------------------------------------------------------------------
  // Slot table model: holds its own copy of the table and a queue of expected
  // results, one per accepted request
  // --------------------------------------------------------------------------
  class probe_table_model;
    slot_state_e        state [Slots];
    logic [KeyW-1:0]    keys [Slots];
    logic [HandleW-1:0] handles [Slots];
    lph_rsp_t           expected_rsps [$];
    int unsigned        failures;

    function new();
      foreach (state[i]) state[i] = SLOT_EMPTY;
      failures = 0;
    endfunction

    // key ends at its first zero byte or after KeyBytes bytes
    function logic [KeyW-1:0] trim_key(logic [KeyW-1:0] raw, output int unsigned len);
      logic [KeyW-1:0] cut;
      cut = '0;
      len = 0;
      while (len < KeyBytes && raw[8*len +: 8] != 8'd0) begin
        cut[8*len +: 8] = raw[8*len +: 8];
        len++;
      end
      return cut;
    endfunction

    function int unsigned home_of(logic [KeyW-1:0] cut, int unsigned len);
      int unsigned h;
      int unsigned c;
      h = 0;
      for (int unsigned i = 0; i < len; i++) begin
        c = cut[8*i +: 8];
        h = ((h + c) * c) % Slots;
      end
      return h;
    endfunction

    function void note_request(lph_req_t r);
      lph_rsp_t        rsp;
      logic [KeyW-1:0] cut;
      int unsigned     len;
      int unsigned     home;
      int unsigned     s;
      rsp  = '0;
      cut  = trim_key(r.key, len);
      home = home_of(cut, len);
      for (int unsigned i = 0; i < Slots; i++) begin
        s = (home + i) % Slots;
        if (r.kind == KIND_INSERT) begin
          // first empty slot only; tombstones are never reused
          if (state[s] == SLOT_EMPTY) begin
            state[s]       = SLOT_USED;
            keys[s]        = cut;
            handles[s]     = r.record_handle;
            rsp.ok         = 1'b1;
            rsp.slot_index = s[SlotOutW-1:0];
            break;
          end
        end else if (r.kind == KIND_LOOKUP || r.kind == KIND_DELETE) begin
          if (state[s] == SLOT_USED && keys[s] == cut) begin
            rsp.ok           = 1'b1;
            rsp.found_handle = handles[s];
            rsp.slot_index   = s[SlotOutW-1:0];
            if (r.kind == KIND_DELETE) state[s] = SLOT_TOMB;
            break;
          end
        end
      end
      expected_rsps.push_back(rsp);
    endfunction

    function void check_result(lph_rsp_t got);
      lph_rsp_t want;
      if (expected_rsps.size() == 0) begin
        $error("unexpected result: ok %0d found_handle %0h slot_index %0d",
               got.ok, got.found_handle, got.slot_index);
        failures++;
        return;
      end
      want = expected_rsps.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, actual %0d", want.ok, got.ok);
        failures++;
      end
      if (got.found_handle !== want.found_handle) begin
        $error("found_handle: expected %0h, actual %0h", want.found_handle,
               got.found_handle);
        failures++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, actual %0d", want.slot_index,
               got.slot_index);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_rsps.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     req_valid = 1'b0;
  logic     req_ready;
  lph_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  lph_rsp_t rsp;

  probe_table_model table_model = new();
  logic [KeyW-1:0]  key_pool [$];     // raw keys of every insert so far
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      cycle_count    = 0;

  linear_probe_hash_table_core #(
    .SLOTS     (Slots),
    .KEY_BYTES (KeyBytes)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_req_i    (req),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_rsp_o   (rsp)
  );

  always #1 clk = ~clk;

  // Run guard: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: ready changes at the falling edge, results are taken at the
  // rising edge on the values held before it
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && rsp_valid && rsp_ready) table_model.check_result(rsp);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // 0..8 nonzero bytes, then a zero byte. Bytes above it are sometimes junk
  // that the block must ignore.
  function automatic logic [KeyW-1:0] random_key();
    int unsigned     len;
    logic [KeyW-1:0] k;
    len = $urandom_range(0, KeyBytes);
    k   = {$urandom, $urandom};
    for (int unsigned i = 0; i < KeyBytes; i++) begin
      if (i < len) begin
        if (k[8*i +: 8] == 8'd0) k[8*i +: 8] = 8'($urandom_range(1, 255));
      end else if (i == len || $urandom_range(1) == 0) begin
        k[8*i +: 8] = 8'd0;
      end
    end
    return k;
  endfunction

  // same cut key, fresh junk after the terminating zero byte
  function automatic logic [KeyW-1:0] rejunk(logic [KeyW-1:0] raw);
    logic [KeyW-1:0] k;
    bit              ended;
    k     = raw;
    ended = 1'b0;
    for (int unsigned i = 0; i < KeyBytes; i++) begin
      if (ended) k[8*i +: 8] = 8'($urandom);
      else if (k[8*i +: 8] == 8'd0) ended = 1'b1;
    end
    return k;
  endfunction

  function automatic logic [KeyW-1:0] known_key();
    logic [KeyW-1:0] k;
    if (key_pool.size() == 0 || $urandom_range(99) < 15) return random_key();
    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    return ($urandom_range(1) == 0) ? rejunk(k) : k;
  endfunction

  // Entered and left at a falling edge. Valid is held until the request is
  // taken, and is only lowered when an idle gap follows.
  task automatic send_request(logic [1:0] kind, logic [KeyW-1:0] key,
                              logic [HandleW-1:0] handle);
    lph_req_t r;
    r.kind          = kind;
    r.key           = key;
    r.record_handle = handle;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    table_model.note_request(r);
    if (kind == KIND_INSERT) key_pool.push_back(key);
    @(negedge clk);
  endtask

  // hold off new requests until every expected result has come back
  task automatic drain_results();
    req_valid <= 1'b0;
    do @(negedge clk); while (table_model.pending() != 0);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      // Inserts are rationed, because tombstones are never reclaimed and the
      // table would soon fill and go dead. Most traffic looks up keys already seen.
      if (pick < 3) send_request(KIND_INSERT, random_key(), 16'($urandom));
      else if (pick < 7) send_request(KIND_DELETE, known_key(), 16'($urandom));
      else if (pick < 9) send_request(KindNone, random_key(), 16'($urandom));
      else send_request(KIND_LOOKUP, known_key(), 16'($urandom));
      if ($urandom_range(99) == 0) drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase one: sender idles lightly, receiver stalls about half the time
    send_idle_pct  = 10;
    recv_stall_pct = 49;

    // empty key hashes to home slot 0
    send_request(KIND_INSERT, 64'h0, 16'hFFFF);
    send_request(KIND_LOOKUP, 64'h0, 16'h0000);
    // widest key, then a duplicate insert that takes the next empty slot
    send_request(KIND_INSERT, '1, 16'h0000);
    send_request(KIND_INSERT, '1, 16'h1234);
    send_request(KIND_LOOKUP, '1, 16'hFFFF);
    // delete leaves a tombstone; the next lookup must probe past it
    send_request(KIND_DELETE, '1, 16'h0000);
    send_request(KIND_LOOKUP, '1, 16'h0000);
    // bytes after the first zero byte are junk and must not matter
    send_request(KIND_INSERT, 64'hDEAD_BEEF_0000_4241, 16'h5A5A);
    send_request(KIND_LOOKUP, 64'h0000_0000_0000_4241, 16'h0000);
    send_request(KIND_DELETE, 64'h1234_5678_9A00_4241, 16'h0000);
    // failed delete and whole key compare misses
    send_request(KIND_DELETE, 64'h0000_0000_0000_4241, 16'h0000);
    send_request(KIND_LOOKUP, 64'h0000_0000_0043_4241, 16'h0000);
    send_request(KIND_LOOKUP, 64'h0000_0000_0000_0041, 16'hFFFF);
    // undefined kind does nothing
    send_request(KindNone, '1, 16'hFFFF);
    send_request(KIND_INSERT, 64'h0101_0101_0101_0101, 16'h8001);
    send_request(KIND_DELETE, 64'h0, 16'h0000);
    send_request(KIND_LOOKUP, 64'h0, 16'h0000);

    run_random(RandomItems / 3);
    drain_results();

    // phase two: sender idles heavily, receiver rarely stalls
    send_idle_pct  = 49;
    recv_stall_pct = 10;
    run_random(RandomItems / 3);
    drain_results();

    // phase three: full rate on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(RandomItems - 2 * (RandomItems / 3));

    // fill the table so the last inserts find no empty slot
    repeat (Slots + 2) send_request(KIND_INSERT, random_key(), 16'($urandom));
    repeat (10) send_request(KIND_LOOKUP, known_key(), 16'($urandom));
    req_valid <= 1'b0;

    while (table_model.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (table_model.failures == 0 && table_model.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/lph_pkg.sv
sv/lph_ram.sv
sv/lph_ctrl.sv
sv/lph_dp.sv
sv/linear_probe_hash_table_core.sv
bench/tb_linear_probe_hash_table_core.sv
